@@ rtl/pip_pkg.sv @@
`timescale 1ns / 1ps
package pip_pkg;

  localparam int PORT_WIDTH  = 32;
  localparam int COORD_WIDTH = 32;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
  localparam int CROSS_WIDTH = PROD_WIDTH + 1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [CROSS_WIDTH-1:0] cross_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    logic signed [PORT_WIDTH-1:0] point_x;
    logic signed [PORT_WIDTH-1:0] point_y;
    logic signed [PORT_WIDTH-1:0] vertex_x;
    logic signed [PORT_WIDTH-1:0] vertex_y;
    logic                         first_vertex;
    logic                         last_vertex;
  } vertex_req_t;

  typedef struct packed {
    logic inside_res;
    logic scan_stopped;
  } result_t;

  typedef struct packed {
    logic s2_load;
    logic s3_load;
  } stage_ctl_t;

  typedef struct packed {
    logic stop;
    logic flip;
  } edge_out_t;

  function automatic coord_t to_coord(logic [PORT_WIDTH-1:0] v);
    return coord_t'(v[COORD_WIDTH-1:0]);
  endfunction

  function automatic logic between(coord_t p, coord_t a, coord_t b);
    return (p >= a && p <= b) || (p <= a && p >= b);
  endfunction

endpackage

@@ rtl/pip_if.sv @@
`timescale 1ns / 1ps
interface pip_vertex_if import pip_pkg::*;;
  logic        valid;
  logic        ready;
  vertex_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pip_result_if import pip_pkg::*;;
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/pip_edge_unit.sv @@
`timescale 1ns / 1ps
module pip_edge_unit import pip_pkg::*; (
  input  logic       clk,
  input  stage_ctl_t ctl,
  input  logic       active,
  input  point_t     a,
  input  point_t     b,
  input  point_t     p,
  output edge_out_t  result
);

  logic  hit_end;
  logic  horiz_hit;
  logic  in_range;
  logic  low_end;

  diff_t dax;
  diff_t dby;
  diff_t dbx;
  diff_t day;
  logic  pre_stop2;
  logic  cand2;
  logic  up2;
  logic  active2;

  prod_t m1;
  prod_t m2;
  logic  pre_stop3;
  logic  cand3;
  logic  up3;
  logic  active3;

  cross_t c;
  logic   c_zero;
  logic   c_pos;

  always_comb begin
    hit_end   = (p == a) || (p == b);
    horiz_hit = (a.y == b.y) && (p.y == a.y) && between(p.x, a.x, b.x);
    in_range  = between(p.y, a.y, b.y);
    low_end   = (p.y == a.y && b.y >= a.y) || (p.y == b.y && a.y >= b.y);
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      dax       <= diff_t'(a.x) - diff_t'(p.x);
      dby       <= diff_t'(b.y) - diff_t'(p.y);
      dbx       <= diff_t'(b.x) - diff_t'(p.x);
      day       <= diff_t'(a.y) - diff_t'(p.y);
      pre_stop2 <= hit_end || horiz_hit;
      cand2     <= in_range && !low_end;
      up2       <= a.y < b.y;
      active2   <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s3_load) begin
      m1        <= dax * dby;
      m2        <= dbx * day;
      pre_stop3 <= pre_stop2;
      cand3     <= cand2;
      up3       <= up2;
      active3   <= active2;
    end
  end

  always_comb begin
    c           = cross_t'(m1) - cross_t'(m2);
    c_zero      = (c == '0);
    c_pos       = !c[CROSS_WIDTH-1] && !c_zero;
    result.stop = active3 && (pre_stop3 || (cand3 && c_zero));
    result.flip = active3 && !pre_stop3 && cand3 && !c_zero && (up3 == c_pos);
  end

endmodule

@@ rtl/point_in_polygon_test_core.sv @@
`timescale 1ns / 1ps
// Crossing-number point-in-polygon test over a vertex stream. One vertex request is taken
// every cycle unless stalled; a last vertex passes s1, s2 and s3 and its result is held in
// an output register, so the pipe keeps flowing until the next last vertex reaches s3. Each
// request checks up to two polygon sides (previous-to-current, and current-to-first on a last
// vertex) through a three-stage pipe: edge classification and coordinate differences, two
// 33x33 signed multiplies per side, then the exact cross-product sign, which updates parity
// and the stop flag. Only last-vertex requests produce a result.
module point_in_polygon_test_core import pip_pkg::*; (
  input logic           clk,
  input logic           rst,
  pip_vertex_if.sink    vtx,
  pip_result_if.source  res
);

  point_t    pt_in;
  point_t    v_in;
  logic      in_fire;

  point_t    first_xy;
  point_t    prev_xy;
  point_t    test_xy;
  logic      parity;
  logic      halted;

  logic      s1_valid;
  point_t    s1_p;
  point_t    s1_prev;
  point_t    s1_v;
  point_t    s1_firstv;
  logic      s1_first;
  logic      s1_last;

  logic      s2_valid;
  logic      s2_first;
  logic      s2_last;
  logic      s3_valid;
  logic      s3_first;
  logic      s3_last;

  logic      out_free;
  logic      s3_go;
  logic      s3_ready;
  logic      s2_ready;
  logic      s2_move;
  logic      s1_ready;
  logic      s1_move;
  stage_ctl_t ctl;

  edge_out_t e0;
  edge_out_t e1;
  logic      par_base;
  logic      halt_base;
  logic      par_mid;
  logic      halt_mid;
  logic      parity_next;
  logic      halted_next;

  always_comb begin
    pt_in.x = to_coord(vtx.data.point_x);
    pt_in.y = to_coord(vtx.data.point_y);
    v_in.x  = to_coord(vtx.data.vertex_x);
    v_in.y  = to_coord(vtx.data.vertex_y);
    in_fire = vtx.valid && vtx.ready;
  end

  always_comb begin
    out_free    = !res.valid || res.ready;
    s3_go       = s3_valid && (!s3_last || out_free);
    s3_ready    = !s3_valid || s3_go;
    s2_move     = s2_valid && s3_ready;
    s2_ready    = !s2_valid || s3_ready;
    s1_move     = s1_valid && s2_ready;
    s1_ready    = !s1_valid || s2_ready;
    vtx.ready   = s1_ready;
    ctl.s2_load = s1_move;
    ctl.s3_load = s2_move;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_xy <= '0;
      prev_xy  <= '0;
      test_xy  <= '0;
    end else if (in_fire) begin
      if (vtx.data.first_vertex) begin
        first_xy <= v_in;
        test_xy  <= pt_in;
      end
      prev_xy <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_p      <= vtx.data.first_vertex ? pt_in : test_xy;
      s1_firstv <= vtx.data.first_vertex ? v_in : first_xy;
      s1_prev   <= prev_xy;
      s1_v      <= v_in;
      s1_first  <= vtx.data.first_vertex;
      s1_last   <= vtx.data.last_vertex;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
      if (s2_move) begin
        s3_valid <= 1'b1;
      end else if (s3_go) begin
        s3_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_first <= s1_first;
      s2_last  <= s1_last;
    end
    if (s2_move) begin
      s3_first <= s2_first;
      s3_last  <= s2_last;
    end
  end

  pip_edge_unit u_edge_prev (
    .clk    (clk),
    .ctl    (ctl),
    .active (!s1_first),
    .a      (s1_prev),
    .b      (s1_v),
    .p      (s1_p),
    .result (e0)
  );

  pip_edge_unit u_edge_close (
    .clk    (clk),
    .ctl    (ctl),
    .active (s1_last),
    .a      (s1_v),
    .b      (s1_firstv),
    .p      (s1_p),
    .result (e1)
  );

  always_comb begin
    par_base    = s3_first ? 1'b0 : parity;
    halt_base   = s3_first ? 1'b0 : halted;
    par_mid     = par_base ^ (!halt_base && e0.flip);
    halt_mid    = halt_base || e0.stop;
    parity_next = par_mid ^ (!halt_mid && e1.flip);
    halted_next = halt_mid || e1.stop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parity <= 1'b0;
      halted <= 1'b0;
    end else if (s3_go) begin
      parity <= parity_next;
      halted <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (s3_go && s3_last) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_go && s3_last) begin
      res.data.inside_res   <= parity_next;
      res.data.scan_stopped <= halted_next;
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    (halted && !(s3_go && s3_first)) |=> halted)
    else $error("stop flag cleared without a first vertex");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    (s3_go && s3_last) |=> (res.valid && res.data.scan_stopped == halted
                            && res.data.inside_res == parity))
    else $error("result does not match scan state");

  a_edge_outcome: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (!(e0.stop && e0.flip) && !(e1.stop && e1.flip)))
    else $error("edge both stops and flips");

  a_s3_hold: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !s3_go) |=> s3_valid)
    else $error("stalled request lost in last stage");

endmodule
